@@ hw/rtl/capped_run_page_allocator_assert.svh @@
// assertion macros shared by the allocator rtl
`ifndef CAPPED_RUN_PAGE_ALLOCATOR_ASSERT_SVH
`define CAPPED_RUN_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// checked only outside reset
`define CRPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define CRPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRPA_ASSERT(lbl, prop, msg)
`define CRPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hw/rtl/crpa_pkg.sv @@
package crpa_pkg;

  localparam int PAGES   = 4096;
  localparam int RUN_CAP = 4;

  localparam int PAGE_W = $clog2(PAGES);
  localparam int LIM_W  = PAGE_W + 1;
  localparam int CNT_W  = $clog2(RUN_CAP + 1);
  localparam int BEST_W = $clog2(RUN_CAP + 2);
  localparam int PRED_W = (RUN_CAP > 1) ? $clog2(RUN_CAP) : 1;

  // field widths of the ports
  localparam int ACTION_W = 2;
  localparam int FIRST_W  = 12;
  localparam int END_W    = 13;
  localparam int LEN_W    = 3;
  localparam int FOUND_W  = 12;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0]   PAGES_IN_USE_RST = CFG_W'(4096);
  localparam logic [FIRST_W-1:0] SEARCH_START_RST = FIRST_W'(256);

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEARCH  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STS_BAD_RANGE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_START = 1'd1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [FIRST_W-1:0]  first_page;
    logic [END_W-1:0]    end_page;
    logic [LEN_W-1:0]    run_length;
  } req_t;

  typedef struct packed {
    logic [FOUND_W-1:0]  found_page;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_ZERO,
    S_REL_RD,
    S_REL_END,
    S_REL_FILL,
    S_PRED_RD,
    S_PRED_EVAL,
    S_SEARCH,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    ADDR_HOLD,
    ADDR_FIRST,
    ADDR_END,
    ADDR_END_M1,
    ADDR_PRED,
    ADDR_START,
    ADDR_INC,
    ADDR_DEC
  } addr_op_t;

  typedef enum logic [1:0] {
    PREV_HOLD,
    PREV_ZERO,
    PREV_END,
    PREV_WANT
  } prev_op_t;

  typedef enum logic [1:0] {
    RES_DONE,
    RES_BAD,
    RES_SEARCH
  } res_kind_t;

  typedef struct packed {
    logic      capture;
    addr_op_t  addr_op;
    logic      rd_en;
    logic      wr_en;
    logic      wr_want;
    prev_op_t  prev_op;
    logic      k_init;
    logic      k_inc;
    logic      srch_eval;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic range_bad;
    logic srch_skip;
    logic addr_lt_limit;
    logic addr_at_first;
    logic addr_at_end_m1;
    logic addr_last_page;
    logic pred_skip;
    logic pred_write;
    logic pred_more;
    logic dv;
    logic exact;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/capped_run_page_allocator.sv @@
// one item at a time, the next accepted once the result sits in the output register
// the scan and the range walks go one page per cycle through the single count memory
// reset: synchronous, active high; then a clearing pass marks every page allocated
// registers reset to pages_in_use 4096 and search_start 256; no item is taken during the pass
module capped_run_page_allocator import crpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // request beats
  input  logic                 in_valid,
  output logic                 in_stall,
  input  req_t                 in_data,
  // response beats
  output logic                 out_valid,
  input  logic                 out_stall,
  output rsp_t                 out_data,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clearing pass, range walks, predecessor fix-up, scan
  crpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: count memory, address walker, best-fit tracking, output register
  crpa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ hw/rtl/crpa_ram.sv @@
module crpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/crpa_ctrl.sv @@
`include "capped_run_page_allocator_assert.svh"
module crpa_ctrl import crpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t    state, state_next;
  res_kind_t kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      kind  <= RES_DONE;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next   = state;
    kind_next    = kind;
    cmd          = '0;
    cmd.addr_op  = ADDR_HOLD;
    cmd.prev_op  = PREV_HOLD;
    cmd.res_kind = kind;
    in_stall     = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.addr_op = ADDR_INC;
        if (sts.addr_last_page) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        kind_next = RES_DONE;
        case (sts.action)
          ACT_ALLOC: begin
            if (sts.range_bad) begin
              kind_next  = RES_BAD;
              state_next = S_RESULT;
            end else begin
              cmd.addr_op = ADDR_FIRST;
              state_next  = S_ZERO;
            end
          end
          ACT_RELEASE: begin
            if (sts.range_bad) begin
              kind_next  = RES_BAD;
              state_next = S_RESULT;
            end else begin
              cmd.addr_op = ADDR_END;
              state_next  = S_REL_RD;
            end
          end
          ACT_SEARCH: begin
            kind_next = RES_SEARCH;
            if (sts.srch_skip) begin
              state_next = S_RESULT;
            end else begin
              cmd.addr_op = ADDR_START;
              state_next  = S_SEARCH;
            end
          end
          default: begin
            kind_next  = RES_BAD;
            state_next = S_RESULT;
          end
        endcase
      end
      S_ZERO: begin
        cmd.wr_en = 1'b1;
        if (sts.addr_at_end_m1) begin
          cmd.prev_op = PREV_ZERO;
          if (sts.pred_skip) begin
            state_next = S_RESULT;
          end else begin
            cmd.addr_op = ADDR_PRED;
            cmd.k_init  = 1'b1;
            state_next  = S_PRED_RD;
          end
        end else begin
          cmd.addr_op = ADDR_INC;
        end
      end
      S_REL_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_REL_END;
      end
      S_REL_END: begin
        cmd.prev_op = PREV_END;
        cmd.addr_op = ADDR_END_M1;
        state_next  = S_REL_FILL;
      end
      S_REL_FILL: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_want = 1'b1;
        cmd.prev_op = PREV_WANT;
        if (sts.addr_at_first) begin
          if (sts.pred_skip) begin
            state_next = S_RESULT;
          end else begin
            cmd.addr_op = ADDR_PRED;
            cmd.k_init  = 1'b1;
            state_next  = S_PRED_RD;
          end
        end else begin
          cmd.addr_op = ADDR_DEC;
        end
      end
      S_PRED_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_PRED_EVAL;
      end
      S_PRED_EVAL: begin
        state_next = S_RESULT;
        if (sts.pred_write) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_want = 1'b1;
          cmd.prev_op = PREV_WANT;
          if (sts.pred_more) begin
            cmd.addr_op = ADDR_DEC;
            cmd.k_inc   = 1'b1;
            state_next  = S_PRED_RD;
          end
        end
      end
      S_SEARCH: begin
        cmd.srch_eval = 1'b1;
        if (sts.addr_lt_limit) begin
          cmd.rd_en   = 1'b1;
          cmd.addr_op = ADDR_INC;
        end
        if (sts.exact || (!sts.addr_lt_limit && !sts.dv)) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  `CRPA_ASSERT_ALWAYS(a_reset_clears, rst |=> state == S_CLEAR, "reset must start the clearing pass")
  `CRPA_ASSERT(a_wr_in_limit, (cmd.wr_en && state != S_CLEAR) |-> sts.addr_lt_limit, "range write past page limit")
  `CRPA_ASSERT(a_load_free, cmd.res_load |-> sts.out_free, "result loaded over a held beat")
  `CRPA_ASSERT(a_idle_quiet, state == S_IDLE |-> !cmd.wr_en && !cmd.rd_en, "store access while idle")

endmodule

@@ hw/rtl/crpa_datapath.sv @@
`include "capped_run_page_allocator_assert.svh"
module crpa_datapath import crpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rsp_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  logic [CFG_W-1:0]   pages_in_use;
  logic [FIRST_W-1:0] search_start;
  req_t               req;
  logic [LIM_W-1:0]   addr, addr_next;
  logic [CNT_W-1:0]   prev, prev_next;
  logic [PRED_W-1:0]  k;
  logic [BEST_W-1:0]  best;
  logic [PAGE_W-1:0]  pos;
  logic [PAGE_W-1:0]  daddr;
  logic               hit;
  logic               dv;

  logic [LIM_W-1:0]   limit;
  logic [LIM_W-1:0]   first_ext;
  logic [LIM_W-1:0]   end_m1;
  logic [CNT_W:0]     prev_inc;
  logic [CNT_W-1:0]   want;
  logic [CNT_W-1:0]   rd_data;
  logic [CNT_W-1:0]   wr_data;
  logic               better;

  // effective page limit
  always_comb begin
    if (pages_in_use < CFG_W'(PAGES)) begin
      limit = LIM_W'(pages_in_use);
    end else begin
      limit = LIM_W'(PAGES);
    end
  end

  assign first_ext = LIM_W'(req.first_page);
  assign end_m1    = LIM_W'(req.end_page) - 1'b1;

  // saturating successor count
  assign prev_inc = {1'b0, prev} + 1'b1;
  assign want     = (prev_inc > (CNT_W + 1)'(RUN_CAP)) ? CNT_W'(RUN_CAP) : prev_inc[CNT_W-1:0];
  assign wr_data  = cmd.wr_want ? want : '0;

  crpa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (PAGES)
  ) u_counts (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (addr[PAGE_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (addr[PAGE_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= PAGES_IN_USE_RST;
      search_start <= SEARCH_START_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAGES_IN_USE: pages_in_use <= cfg_data;
        REG_SEARCH_START: search_start <= cfg_data[FIRST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cmd.addr_op)
      ADDR_FIRST:  addr_next = first_ext;
      ADDR_END:    addr_next = LIM_W'(req.end_page);
      ADDR_END_M1: addr_next = end_m1;
      ADDR_PRED:   addr_next = first_ext - 1'b1;
      ADDR_START:  addr_next = LIM_W'(search_start);
      ADDR_INC:    addr_next = addr + 1'b1;
      ADDR_DEC:    addr_next = addr - 1'b1;
      default:     addr_next = addr;
    endcase
  end

  always_comb begin
    case (cmd.prev_op)
      PREV_ZERO: prev_next = '0;
      PREV_END:  prev_next = (LIM_W'(req.end_page) < limit) ? rd_data : '0;
      PREV_WANT: prev_next = want;
      default:   prev_next = prev;
    endcase
  end

  assign better = dv && (LEN_W'(rd_data) >= req.run_length) && (BEST_W'(rd_data) < best);

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      prev <= '0;
      k    <= '0;
      hit  <= 1'b0;
      best <= '0;
      dv   <= 1'b0;
    end else begin
      addr <= addr_next;
      prev <= prev_next;
      dv   <= cmd.rd_en;
      if (cmd.k_init) begin
        k <= PRED_W'(1);
      end else if (cmd.k_inc) begin
        k <= k + 1'b1;
      end
      if (cmd.capture) begin
        hit  <= 1'b0;
        best <= BEST_W'(RUN_CAP + 1);
      end else if (cmd.srch_eval && better) begin
        hit  <= 1'b1;
        best <= BEST_W'(rd_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data;
    end
    if (cmd.rd_en) begin
      daddr <= addr[PAGE_W-1:0];
    end
    if (cmd.srch_eval && better) begin
      pos <= daddr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_kind)
        RES_BAD: begin
          out_data.found_page <= '0;
          out_data.status     <= STS_BAD_RANGE;
        end
        RES_SEARCH: begin
          out_data.found_page <= hit ? FOUND_W'(pos) : '0;
          out_data.status     <= hit ? STS_DONE : STS_NOT_FOUND;
        end
        default: begin
          out_data.found_page <= '0;
          out_data.status     <= STS_DONE;
        end
      endcase
    end
  end

  always_comb begin
    sts.action         = req.action;
    sts.range_bad      = (first_ext >= LIM_W'(req.end_page)) ||
                         (LIM_W'(req.end_page) > limit);
    sts.srch_skip      = (req.run_length == '0) || (req.run_length > LEN_W'(RUN_CAP)) ||
                         (LIM_W'(search_start) >= limit);
    sts.addr_lt_limit  = addr < limit;
    sts.addr_at_first  = addr == first_ext;
    sts.addr_at_end_m1 = addr == end_m1;
    sts.addr_last_page = addr == LIM_W'(PAGES - 1);
    sts.pred_skip      = (req.first_page == '0) || (RUN_CAP == 1);
    if (req.action == ACT_ALLOC) begin
      sts.pred_write = rd_data > want;
    end else begin
      sts.pred_write = (rd_data != '0) && (rd_data < want);
    end
    sts.pred_more      = (k < PRED_W'(RUN_CAP - 1)) && (addr != '0);
    sts.dv             = dv;
    sts.exact          = dv && (LEN_W'(rd_data) == req.run_length);
    sts.out_free       = !out_valid || !out_stall;
  end

  `CRPA_ASSERT(a_best_range, hit |-> (BEST_W'(req.run_length) <= best) && (best <= BEST_W'(RUN_CAP)), "best fit outside wanted range")
  `CRPA_ASSERT(a_miss_zero, (out_valid && out_data.status != STS_DONE) |-> (out_data.found_page == '0), "page reported without a hit")

endmodule

@@ tb/tb_capped_run_page_allocator.sv @@
`timescale 1ns / 100ps

module tb_capped_run_page_allocator;
  import crpa_pkg::*;

  // action 3 is not decoded by the block
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // clock, reset and dut ports; every input starts at a known value
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  req_t                 in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rsp_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  capped_run_page_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the allocator: per-page run counts and both registers
  logic [CNT_W-1:0] page_runs [PAGES];
  logic [CFG_W-1:0]   limit_reg = PAGES_IN_USE_RST;
  logic [FIRST_W-1:0] start_reg = SEARCH_START_RST;

  // responses owed by the block, oldest first
  rsp_t awaited_rsp[$];
  rsp_t head_rsp;
  int unsigned bad_beats = 0;

  // when set, neither side idles
  bit no_idle = 1'b0;

  // one directed step: either a request beat or a register write
  typedef struct {
    bit                   is_cfg;
    req_t                 req;
    logic [CFG_IDX_W-1:0] idx;
    int unsigned          value;
    bit                   known;
    rsp_t                 rsp;
  } step_row_t;

  step_row_t directed_rows[$];

  // ---------------------------------------------------------------
  // shadow allocator
  // ---------------------------------------------------------------

  // pages at or above the managed count read as allocated
  function automatic int unsigned page_limit();
    return (limit_reg < PAGES) ? limit_reg : PAGES;
  endfunction

  // count a free page at p would have, given the page after it
  function automatic int unsigned next_count(int unsigned p);
    int unsigned c;
    c = ((p + 1 >= page_limit()) ? 0 : page_runs[p + 1]) + 1;
    return (c > RUN_CAP) ? RUN_CAP : c;
  endfunction

  // zero the range, then shorten the runs of free pages just before it
  function automatic void claim_range(int unsigned first, int unsigned fin);
    int unsigned i, k, p, want;
    bit stop;
    stop = 1'b0;
    for (i = first; i < fin; i++) page_runs[i] = '0;
    for (k = 1; k < RUN_CAP && k <= first && !stop; k++) begin
      p = first - k;
      want = next_count(p);
      if (page_runs[p] > want) page_runs[p] = CNT_W'(want);
      else stop = 1'b1;
    end
  endfunction

  // rebuild the range from its top down, then lengthen free runs before it
  function automatic void return_range(int unsigned first, int unsigned fin);
    int unsigned i, k, p, want;
    bit stop;
    stop = 1'b0;
    for (i = fin; i > first; i--) page_runs[i - 1] = CNT_W'(next_count(i - 1));
    for (k = 1; k < RUN_CAP && k <= first && !stop; k++) begin
      p = first - k;
      if (page_runs[p] == 0) begin
        stop = 1'b1;
      end else begin
        want = next_count(p);
        if (page_runs[p] < want) page_runs[p] = CNT_W'(want);
        else stop = 1'b1;
      end
    end
  endfunction

  // exact fit wins at once, else the first of the smallest big-enough runs
  function automatic bit best_fit(input int unsigned len, output int unsigned pos);
    int unsigned best, i, lim;
    bit hit, stop;
    pos = 0;
    hit = 1'b0;
    stop = 1'b0;
    best = RUN_CAP + 1;
    lim = page_limit();
    if (len == 0 || len > RUN_CAP) return 1'b0;
    for (i = start_reg; i < lim && !stop; i++) begin
      if (page_runs[i] >= len && page_runs[i] < best) begin
        best = page_runs[i];
        pos = i;
        hit = 1'b1;
        if (page_runs[i] == len) stop = 1'b1;
      end
    end
    return hit;
  endfunction

  // response for one request beat; updates the shadow counts
  function automatic rsp_t compute_outcome(req_t r);
    rsp_t o;
    int unsigned pos;
    o = '0;
    o.status = STS_DONE;
    pos = 0;
    if (r.action == ACT_ALLOC || r.action == ACT_RELEASE) begin
      if (r.first_page >= r.end_page || r.end_page > page_limit()) begin
        o.status = STS_BAD_RANGE;
      end else if (r.action == ACT_ALLOC) begin
        claim_range(r.first_page, r.end_page);
      end else begin
        return_range(r.first_page, r.end_page);
      end
    end else if (r.action == ACT_SEARCH) begin
      if (best_fit(r.run_length, pos)) o.found_page = FOUND_W'(pos);
      else o.status = STS_NOT_FOUND;
    end else begin
      o.status = STS_BAD_RANGE;
    end
    return o;
  endfunction

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  // mostly well-formed ranges and searches inside the window, some noise
  function automatic req_t random_request(int unsigned lim, int unsigned win_lo);
    req_t r;
    int unsigned roll, first, span, fin;
    roll  = $urandom_range(0, 99);
    first = win_lo + $urandom_range(0, lim - 1 - win_lo);
    span  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                       : $urandom_range(1, lim - first);
    fin   = (first + span > lim) ? lim : first + span;
    r.first_page = FIRST_W'(first);
    r.end_page   = END_W'(fin);
    r.run_length = LEN_W'($urandom_range(1, RUN_CAP));
    if (roll < 40) begin
      r.action = ACT_RELEASE;
    end else if (roll < 65) begin
      r.action = ACT_ALLOC;
    end else if (roll < 90) begin
      r.action = ACT_SEARCH;
    end else begin
      r.action = ($urandom_range(0, 1) == 0) ? ACT_ALLOC : ACT_RELEASE;
      case ($urandom_range(0, 3))
        0: begin
          // undecoded action with random content
          r = req_t'($urandom);
          r.action = ACT_UNUSED;
        end
        1: begin
          // length of 0 or above the cap
          r.action = ACT_SEARCH;
          r.run_length = LEN_W'($urandom_range(5, 8));
        end
        2: r.end_page = END_W'($urandom_range(0, first));
        default: r.end_page = END_W'($urandom_range(lim + 1, 8191));
      endcase
    end
    return r;
  endfunction

  // present one request beat, record its response at acceptance, then idle;
  // valid stays high into the next beat unless a gap or a drain follows
  task automatic send_req(input req_t r, input bit known, input rsp_t known_rsp,
                          input bit lower_after);
    rsp_t pred;
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = compute_outcome(r);
    awaited_rsp.push_back(known ? known_rsp : pred);
    gap = pick_gap();
    if (gap != 0 || lower_after) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // every owed response has arrived, plus a short settle
  task automatic wait_idle();
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    if (idx == REG_PAGES_IN_USE) limit_reg = CFG_W'(value);
    else start_reg = FIRST_W'(value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_beat(input logic [ACTION_W-1:0] act, input int unsigned first,
                          input int unsigned fin, input int unsigned len);
    step_row_t row;
    row = '{default: '0};
    row.req = '{action: act, first_page: FIRST_W'(first), end_page: END_W'(fin),
                run_length: LEN_W'(len)};
    directed_rows.push_back(row);
  endtask

  // same, with the response typed in
  task automatic add_known(input logic [ACTION_W-1:0] act, input int unsigned first,
                           input int unsigned fin, input int unsigned len,
                           input int unsigned found, input logic [STATUS_W-1:0] sts);
    add_beat(act, first, fin, len);
    directed_rows[$].known = 1'b1;
    directed_rows[$].rsp = '{found_page: FOUND_W'(found), status: sts};
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    step_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.value = value;
    directed_rows.push_back(row);
  endtask

  // one random phase under one register setting
  task automatic run_phase(input int unsigned lim, input int unsigned start,
                           input int unsigned win_lo, input int unsigned n_beats,
                           input bit quiet);
    int unsigned j;
    write_reg(REG_PAGES_IN_USE, lim);
    write_reg(REG_SEARCH_START, start);
    no_idle <= quiet;
    for (j = 0; j < n_beats; j++)
      send_req(random_request(lim, win_lo), 1'b0, '0, j + 1 == n_beats);
    wait_idle();
  endtask

  // ---------------------------------------------------------------
  // receiver: random stall stretches, checked response beats
  // ---------------------------------------------------------------

  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= !no_idle && ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  // compare each response beat with the oldest owed response
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_rsp.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("unexpected response beat: found_page %0d status %0d",
                   out_data.found_page, out_data.status);
      end else begin
        head_rsp = awaited_rsp.pop_front();
        if (out_data.found_page !== head_rsp.found_page ||
            out_data.status !== head_rsp.status) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("response mismatch: expected found_page %0d status %0d, got %0d %0d",
                     head_rsp.found_page, head_rsp.status,
                     out_data.found_page, out_data.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------

  initial begin
    int unsigned i;
    foreach (page_runs[p]) page_runs[p] = '0;

    // directed table, reset setting first: every page allocated
    add_known(ACT_SEARCH, 0, 0, 1, 0, STS_NOT_FOUND);
    add_known(ACT_UNUSED, 0, 0, 0, 0, STS_BAD_RANGE);
    add_known(ACT_ALLOC, 5, 5, 0, 0, STS_BAD_RANGE);        // empty range
    add_known(ACT_RELEASE, 0, 4097, 0, 0, STS_BAD_RANGE);   // end past the limit
    add_known(ACT_RELEASE, 4095, 4096, 0, 0, STS_DONE);     // top page only
    add_known(ACT_SEARCH, 0, 0, 1, 4095, STS_DONE);
    add_known(ACT_SEARCH, 0, 0, 2, 0, STS_NOT_FOUND);
    // small window scanned from page 0
    add_cfg(REG_PAGES_IN_USE, 64);
    add_cfg(REG_SEARCH_START, 0);
    add_known(ACT_RELEASE, 0, 64, 0, 0, STS_DONE);
    add_beat(ACT_SEARCH, 0, 0, 4);
    add_beat(ACT_SEARCH, 0, 0, 1);
    add_known(ACT_SEARCH, 0, 0, 0, 0, STS_NOT_FOUND);       // zero length
    add_known(ACT_SEARCH, 0, 0, 7, 0, STS_NOT_FOUND);       // above the cap
    add_known(ACT_ALLOC, 10, 12, 0, 0, STS_DONE);
    add_beat(ACT_SEARCH, 0, 0, 2);
    add_beat(ACT_SEARCH, 0, 0, 3);
    add_beat(ACT_RELEASE, 11, 12, 0);
    add_beat(ACT_ALLOC, 0, 1, 0);
    add_beat(ACT_ALLOC, 20, 64, 0);
    add_beat(ACT_SEARCH, 0, 0, 4);
    // single managed page, counts above it left stale
    add_cfg(REG_PAGES_IN_USE, 1);
    add_beat(ACT_RELEASE, 0, 1, 0);
    add_beat(ACT_SEARCH, 0, 0, 1);
    add_known(ACT_ALLOC, 0, 2, 0, 0, STS_BAD_RANGE);
    // full store, search starting at the last page
    add_cfg(REG_PAGES_IN_USE, 4096);
    add_cfg(REG_SEARCH_START, 4095);
    add_beat(ACT_SEARCH, 0, 0, 1);
    add_beat(ACT_ALLOC, 4095, 4096, 0);
    add_known(ACT_SEARCH, 0, 0, 1, 0, STS_NOT_FOUND);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // the first beats simply wait out the clearing pass on in_stall
    for (i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_req(directed_rows[i].req, directed_rows[i].known, directed_rows[i].rsp,
                 (i + 1 == directed_rows.size()) || directed_rows[i + 1].is_cfg);
      end
    end
    wait_idle();

    // random phases: window, start, range window low end, beats, no idling
    run_phase(48, 0, 0, 22, 1'b0);
    run_phase(200, 17, 0, 20, 1'b1);
    run_phase(4096, 4000, 3980, 20, 1'b0);   // top of the store
    run_phase(1, 0, 0, 8, 1'b0);
    run_phase(4096, 0, 0, 8, 1'b0);          // full-length scans, kept few
    run_phase(100, 4095, 0, 10, 1'b0);       // search start past the limit
    run_phase(33, 5, 0, 22, 1'b0);
    run_phase(16, 15, 0, 14, 1'b0);

    repeat (20) @(posedge clk);
    if (bad_beats == 0 && awaited_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/crpa_pkg.sv
hw/rtl/crpa_ram.sv
hw/rtl/crpa_ctrl.sv
hw/rtl/crpa_datapath.sv
hw/rtl/capped_run_page_allocator.sv
tb/tb_capped_run_page_allocator.sv
